// File: design/grq_pkg.sv
// Shared constants, types and helpers for the graph reachability block.
`timescale 1ns / 1ps

package grq_pkg;

   localparam int MAX_VERTICES  = 32;
   localparam int VTX_W         = $clog2(MAX_VERTICES);
   localparam int CNT_W         = $clog2(MAX_VERTICES + 1);
   localparam int OP_W          = 2;
   localparam int VTX_FIELD_W   = 5;
   localparam int COUNT_FIELD_W = 6;

   localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [VTX_W-1:0]        vtx_type;

   typedef struct packed {
      logic    rd_en;
      vtx_type rd_addr;
      logic    wr_en;
      vtx_type wr_addr;
      row_type wr_data;
      logic    clear_all;
   } mem_req_type;

   // vertex_count saturated at the matrix size
   function automatic logic [CNT_W-1:0] active_count(logic [COUNT_FIELD_W-1:0] cnt);
      if (32'(cnt) > MAX_VERTICES) return CNT_W'(MAX_VERTICES);
      return CNT_W'(cnt);
   endfunction

   function automatic logic in_range(logic [VTX_FIELD_W-1:0] v, logic [CNT_W-1:0] n);
      return 32'(v) < 32'(n);
   endfunction

   function automatic row_type range_mask(logic [CNT_W-1:0] n);
      row_type m;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         m[i] = (i < 32'(n));
      end
      return m;
   endfunction

   function automatic row_type vtx_onehot(vtx_type v);
      row_type r;
      r    = '0;
      r[v] = 1'b1;
      return r;
   endfunction

endpackage

// File: design/grq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module grq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/grq_engine.sv
// Command sequencer: edge read-modify-write and frontier search over adjacency rows.
`timescale 1ns / 1ps

module grq_engine import grq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [VTX_FIELD_W-1:0]   req_from_vertex,
   input  logic [VTX_FIELD_W-1:0]   req_to_vertex,
   input  logic [COUNT_FIELD_W-1:0] vertex_count,
   input  row_type                  row_data,
   output mem_req_type              mem_req,
   output logic                     rsp_strobe,
   output logic                     rsp_reachable,
   output logic                     rsp_out_of_range
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_EDGE_WR = 3'b010,
      ST_SEARCH  = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   row_type    seen_ff, seen_in;
   row_type    visited_ff, visited_in;
   vtx_type    goal_ff, goal_in;
   logic       inflight_ff, inflight_in;
   vtx_type    edge_src_ff, edge_src_in;
   row_type    edge_bit_ff, edge_bit_in;
   logic       strobe_ff, strobe_in;
   logic       reach_ff, reach_in;
   logic       oor_ff, oor_in;

   logic [CNT_W-1:0] n_eff;
   row_type          mask;
   row_type          merged;
   row_type          pending;
   row_type          pick_oh;
   vtx_type          pick_idx;

   always_comb begin
      n_eff   = active_count(vertex_count);
      mask    = range_mask(n_eff);
      merged  = seen_ff | (inflight_ff ? (row_data & mask) : '0);
      pending = merged & mask & ~visited_ff;
      pick_oh = pending & (~pending + row_type'(1));
      pick_idx = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (pick_oh[i]) pick_idx = pick_idx | VTX_W'(i);
      end
   end

   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      visited_in  = visited_ff;
      goal_in     = goal_ff;
      inflight_in = 1'b0;
      edge_src_in = edge_src_ff;
      edge_bit_in = edge_bit_ff;
      strobe_in   = 1'b0;
      reach_in    = reach_ff;
      oor_in      = oor_ff;
      mem_req     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  OP_ADD_EDGE: begin
                     if (in_range(req_from_vertex, n_eff) && in_range(req_to_vertex, n_eff)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = VTX_W'(req_from_vertex);
                        edge_src_in     = VTX_W'(req_from_vertex);
                        edge_bit_in     = vtx_onehot(VTX_W'(req_to_vertex));
                        state_in        = ST_EDGE_WR;
                     end
                  end
                  OP_CLEAR: begin
                     mem_req.clear_all = 1'b1;
                  end
                  OP_QUERY: begin
                     if (req_from_vertex == req_to_vertex) begin
                        strobe_in = 1'b1;
                        reach_in  = 1'b1;
                        oor_in    = 1'b0;
                     end else if (!in_range(req_from_vertex, n_eff) ||
                                  !in_range(req_to_vertex, n_eff)) begin
                        strobe_in = 1'b1;
                        reach_in  = 1'b0;
                        oor_in    = 1'b1;
                     end else begin
                        seen_in    = vtx_onehot(VTX_W'(req_from_vertex));
                        visited_in = '0;
                        goal_in    = VTX_W'(req_to_vertex);
                        state_in   = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = edge_src_ff;
            mem_req.wr_data = row_data | edge_bit_ff;
            state_in        = ST_IDLE;
         end
         ST_SEARCH: begin
            seen_in = merged;
            if (merged[goal_ff]) begin
               strobe_in = 1'b1;
               reach_in  = 1'b1;
               oor_in    = 1'b0;
               state_in  = ST_IDLE;
            end else if (pending == '0) begin
               strobe_in = 1'b1;
               reach_in  = 1'b0;
               oor_in    = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               // one row per cycle; the row arrives next cycle and is merged then
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pick_idx;
               visited_in      = visited_ff | pick_oh;
               inflight_in     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         inflight_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= inflight_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      seen_ff     <= seen_in;
      visited_ff  <= visited_in;
      goal_ff     <= goal_in;
      edge_src_ff <= edge_src_in;
      edge_bit_ff <= edge_bit_in;
      reach_ff    <= reach_in;
      oor_ff      <= oor_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_reachable    = reach_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

// File: design/graph_reachability_query.sv
// Top level of the directed-graph reachability block.
// Holds a directed graph of up to 32 vertices as an adjacency matrix, one row per vertex
// in a RAM. Commands are taken when start is high and busy is low. Clear-graph never
// raises busy; add-edge reads and writes back the source row and keeps busy high for
// one cycle, and an add-edge with an out-of-range endpoint is dropped. A query with
// equal endpoints or an out-of-range endpoint answers on rsp_strobe in the next cycle.
// Any other query walks the graph one adjacency row per cycle through the RAM's single
// read port, merging each row into the seen set until the end vertex is seen or no seen
// vertex is left unvisited, with busy high throughout. Each result is shown for exactly
// one cycle and cannot be held off. Row valid flops clear the graph at reset and on
// clear, so there is no clearing pass. Write csr_wr_data only while idle.
`timescale 1ns / 1ps

module graph_reachability_query import grq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [VTX_FIELD_W-1:0]   req_from_vertex,
   input  logic [VTX_FIELD_W-1:0]   req_to_vertex,
   output logic                     rsp_strobe,
   output logic                     rsp_reachable,
   output logic                     rsp_out_of_range,
   input  logic                     csr_wr_en,
   input  logic [COUNT_FIELD_W-1:0] csr_wr_data
);

   logic [COUNT_FIELD_W-1:0] vertex_count_ff;
   row_type                  row_valid_ff;
   logic                     rd_valid_ff;
   row_type                  ram_rd_data;
   row_type                  row_data;
   mem_req_type              mem_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_req.clear_all) begin
         row_valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         row_valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_valid_ff <= row_valid_ff[mem_req.rd_addr];
      end
   end

   // a row never written since reset or clear reads as empty
   assign row_data = rd_valid_ff ? ram_rd_data : '0;

   grq_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   grq_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .vertex_count     (vertex_count_ff),
      .row_data         (row_data),
      .mem_req          (mem_req),
      .rsp_strobe       (rsp_strobe),
      .rsp_reachable    (rsp_reachable),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// File: design/grq_checker.sv
// Port-level checker for the graph reachability block, bound to the top level.
`timescale 1ns / 1ps

module grq_checker import grq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [OP_W-1:0]          req_operation,
   input logic [VTX_FIELD_W-1:0]   req_from_vertex,
   input logic [VTX_FIELD_W-1:0]   req_to_vertex,
   input logic                     rsp_strobe,
   input logic                     rsp_reachable,
   input logic                     rsp_out_of_range
);

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_reachable && rsp_out_of_range))
      else $error("reachable and out_of_range both set");

   a_same_vertex: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_QUERY && req_from_vertex == req_to_vertex)
      |=> (rsp_strobe && rsp_reachable && !rsp_out_of_range))
      else $error("query with equal endpoints not answered reachable next cycle");

   a_no_result_for_non_query: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation != OP_QUERY) |=> !rsp_strobe)
      else $error("result after a non-query item");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy || start)))
      else $error("result strobe without a preceding query or search");

endmodule

bind graph_reachability_query grq_checker u_grq_checker (.*);
